@@ rtl/mvt_pkg.sv @@
// Shared types and constants for the 4x4 vertex transform block.
// No dependencies; every other file of the block imports this package.
package mvt_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Command codes of an input transaction.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  // Transform modes; the unused code behaves as homogeneous.
  localparam logic [1:0] MODE_HOMOG = 2'd0;
  localparam logic [1:0] MODE_PROJ  = 2'd1;
  localparam logic [1:0] MODE_DIR   = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  // One queued transform: selected coefficients per row and the vector.
  typedef struct packed {
    logic [1:0]             mode;
    logic [3:0][3:0][31:0]  coef;
    logic [3:0][31:0]       vec;
  } xform_t;

  // Data that travels alongside the divider lanes.
  typedef struct packed {
    logic [1:0]        mode;
    logic              zero_w;
    logic [2:0]        neg;
    logic [3:0][31:0]  res;
  } side_t;

endpackage

@@ rtl/matrix_vertex_transform_top.sv @@
// Top level of the 4x4 vertex transform: front end, queue and back end.
// Depends on mvt_pkg, mvt_front, mvt_queue and mvt_back.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  command, entry index and value, x y z w, mode, transpose
//   out      out_valid/ out_stall x y z w results, divide_by_zero flag
//
// One transaction per clock is accepted and one result per clock delivered
// while neither side stalls. Every transform passes through the divider,
// which produces one quotient bit per stage.
// Loads produce no result.
// Reset (synchronous, active low) clears the matrix and empties all stages.
// An output stall while a result is presented freezes the back end; the queue then fills and stalls input.
module matrix_vertex_transform_top #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [3:0]          in_entry_index,
  input  logic signed [31:0]  in_entry_value,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic signed [31:0]  in_w,
  input  logic [1:0]          in_mode,
  input  logic                in_use_transpose,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_w,
  output logic                out_divide_by_zero
);
  import mvt_pkg::*;

  logic    q_full, q_empty, push, pop;
  xform_t  push_data, head;

  mvt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_z             (in_z),
    .in_w             (in_w),
    .in_mode          (in_mode),
    .in_use_transpose (in_use_transpose),
    .q_full           (q_full),
    .push             (push),
    .push_data        (push_data)
  );

  mvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (q_empty),
    .full      (q_full),
    .head      (head)
  );

  mvt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (!q_empty),
    .q_head             (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_z              (out_z),
    .out_w              (out_w),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

@@ rtl/mvt_front.sv @@
// Front end: holds the matrix, executes loads and builds transform entries.
// Depends on mvt_pkg.
module mvt_front #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [3:0]          in_entry_index,
  input  logic signed [31:0]  in_entry_value,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic signed [31:0]  in_w,
  input  logic [1:0]          in_mode,
  input  logic                in_use_transpose,
  input  logic                q_full,
  output logic                push,
  output mvt_pkg::xform_t     push_data
);
  import mvt_pkg::*;

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [31:0] mat_r [16];
  logic        accept;

  // A transaction is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (in_command == CMD_XFORM);

  // Matrix storage; loads write one entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) mat_r[k] <= '0;
    end else if (accept && (in_command == CMD_LOAD)) begin
      mat_r[in_entry_index] <= in_entry_value;
    end
  end

  // Coefficient selection for plain or transposed product; direction mode
  // drops the fourth column.
  always_comb begin
    logic [3:0] idx;
    idx = '0;
    push_data.mode = in_mode;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        idx = in_use_transpose ? 4'(j * 4 + i) : 4'(i * 4 + j);
        if ((in_mode == MODE_DIR) && (j == 3)) begin
          push_data.coef[i][j] = '0;
        end else begin
          push_data.coef[i][j] = mat_r[idx];
        end
      end
    end
    push_data.vec[0] = in_x;
    push_data.vec[1] = in_y;
    push_data.vec[2] = in_z;
    push_data.vec[3] = (in_mode == MODE_PROJ) ? ONE : in_w;
  end

endmodule

@@ rtl/mvt_queue.sv @@
// Two-entry queue between the front end and the arithmetic back end.
// Depends on mvt_pkg.
module mvt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mvt_pkg::xform_t  push_data,
  input  logic             pop,
  output logic             empty,
  output logic             full,
  output mvt_pkg::xform_t  head
);
  import mvt_pkg::*;

  xform_t      ent_r [2];
  logic        rd_ptr_r, wr_ptr_r;
  logic [1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = ent_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/mvt_back.sv @@
// Back end: products, rounded dot sums, pipelined divide and output register.
// Depends on mvt_pkg.
module mvt_back #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mvt_pkg::xform_t     q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_w,
  output logic                out_divide_by_zero
);
  import mvt_pkg::*;

  // Dividend width: magnitude of a 32-bit value shifted up by FRAC_BITS.
  localparam int NW = 32 + FRAC_BITS;
  localparam logic [31:0]        ONE     = 32'd1 << FRAC_BITS;
  localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic [NW-1:0]      Q_POS   = NW'(32'h7fffffff);
  localparam logic [NW-1:0]      Q_NEG   = NW'(32'h80000000);

  logic adv;

  // Whole pipeline moves unless a finished result is being held.
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_valid;

  // Stage 1: sixteen products.
  logic                p_vld_r;
  logic [1:0]          p_mode_r;
  logic signed [63:0]  p_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else if (adv) p_vld_r <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mode_r <= q_head.mode;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_r[i][j] <= $signed(q_head.coef[i][j]) * $signed(q_head.vec[j]);
        end
      end
    end
  end

  // Stage 2: exact row sums, rounded to nearest with ties upward, saturated; direction mode zeroes the fourth.
  logic              s_vld_r;
  logic [1:0]        s_mode_r;
  logic [3:0][31:0]  s_res_r, s_res_nxt;

  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    acc = '0;
    sh  = '0;
    for (int i = 0; i < 4; i++) begin
      acc = 66'(p_r[i][0]) + 66'(p_r[i][1]) + 66'(p_r[i][2]) + 66'(p_r[i][3]) + HALF;
      sh  = acc >>> FRAC_BITS;
      if (sh > S32_MAX)      s_res_nxt[i] = 32'h7fffffff;
      else if (sh < S32_MIN) s_res_nxt[i] = 32'h80000000;
      else                   s_res_nxt[i] = sh[31:0];
    end
    if (p_mode_r == MODE_DIR) s_res_nxt[3] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r <= 1'b0;
    else if (adv) s_vld_r <= p_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_mode_r <= p_mode_r;
      s_res_r  <= s_res_nxt;
    end
  end

  // Divider pipeline: stage 0 holds magnitudes, each later stage one
  // restoring quotient bit. The dividend register gathers quotient bits.
  logic              d_vld_r  [NW+1];
  side_t             d_side_r [NW+1];
  logic [31:0]       d_div_r  [NW+1];
  logic [NW-1:0]     d_num_r  [NW+1][3];
  logic [31:0]       d_rem_r  [NW+1][3];

  side_t             side0_nxt;
  logic [31:0]       div0_nxt;
  logic [NW-1:0]     num0_nxt [3];

  always_comb begin
    logic [31:0] w;
    logic [31:0] mag;
    w   = s_res_r[3];
    mag = '0;
    side0_nxt.mode   = s_mode_r;
    side0_nxt.res    = s_res_r;
    side0_nxt.zero_w = (s_mode_r == MODE_PROJ) && (w == 32'd0);
    div0_nxt         = w[31] ? (32'd0 - w) : w;
    for (int i = 0; i < 3; i++) begin
      side0_nxt.neg[i] = s_res_r[i][31] ^ w[31];
      mag              = s_res_r[i][31] ? (32'd0 - s_res_r[i]) : s_res_r[i];
      num0_nxt[i]      = {mag, {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r[0] <= 1'b0;
    else if (adv) d_vld_r[0] <= s_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side_r[0] <= side0_nxt;
      d_div_r[0]  <= div0_nxt;
      for (int i = 0; i < 3; i++) begin
        d_num_r[0][i] <= num0_nxt[i];
        d_rem_r[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [NW-1:0] num_nxt [3];
    logic [31:0]   rem_nxt [3];

    // One compare and subtract per lane.
    always_comb begin
      logic [32:0] t;
      logic        ge;
      t  = '0;
      ge = 1'b0;
      for (int i = 0; i < 3; i++) begin
        t  = {d_rem_r[k][i], d_num_r[k][i][NW-1]};
        ge = (t >= {1'b0, d_div_r[k]});
        rem_nxt[i] = ge ? 32'(t - {1'b0, d_div_r[k]}) : t[31:0];
        num_nxt[i] = {d_num_r[k][i][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) d_vld_r[k+1] <= 1'b0;
      else if (adv) d_vld_r[k+1] <= d_vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_side_r[k+1] <= d_side_r[k];
        d_div_r[k+1]  <= d_div_r[k];
        for (int i = 0; i < 3; i++) begin
          d_num_r[k+1][i] <= num_nxt[i];
          d_rem_r[k+1][i] <= rem_nxt[i];
        end
      end
    end
  end

  // Output formatting: signed, saturated quotients, zeros with the divide-by-zero flag, or the plain sums.
  logic               out_valid_r;
  logic [3:0][31:0]   out_res_r, out_res_nxt;
  logic               out_dz_r, out_dz_nxt;

  always_comb begin
    logic [NW-1:0] q;
    side_t         sd;
    q  = '0;
    sd = d_side_r[NW];
    out_res_nxt = sd.res;
    out_dz_nxt  = 1'b0;
    case (sd.mode)
      MODE_PROJ: begin
        if (sd.zero_w) begin
          out_res_nxt = '0;
          out_dz_nxt  = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            q = d_num_r[NW][i];
            if (sd.neg[i]) begin
              out_res_nxt[i] = (q > Q_NEG) ? 32'h80000000 : (32'd0 - q[31:0]);
            end else begin
              out_res_nxt[i] = (q > Q_POS) ? 32'h7fffffff : q[31:0];
            end
          end
          out_res_nxt[3] = ONE;
        end
      end
      default: begin
        out_res_nxt = sd.res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= d_vld_r[NW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= out_res_nxt;
      out_dz_r  <= out_dz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_x              = out_res_r[0];
  assign out_y              = out_res_r[1];
  assign out_z              = out_res_r[2];
  assign out_w              = out_res_r[3];
  assign out_divide_by_zero = out_dz_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for matrix_vertex_transform_top: matrix loads and
// vector transforms in all modes, checked against an internal predictor.
// Depends on mvt_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvt_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int LATENCY = FB + 37;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic        command;
    logic [3:0]  index;
    logic [31:0] value;
    logic [31:0] x, y, z, w;
    logic [1:0]  mode;
    logic        transpose;
  } vtx_cmd_t;

  typedef struct {
    logic [31:0] x, y, z, w;
    logic        dbz;
  } vtx_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic in_command, in_use_transpose, out_divide_by_zero;
  logic [3:0] in_entry_index;
  logic [1:0] in_mode;
  logic signed [31:0] in_entry_value, in_x, in_y, in_z, in_w;
  logic signed [31:0] out_x, out_y, out_z, out_w;

  matrix_vertex_transform_top dut (.*);

  // Predictor state: the matrix as the block should hold it.
  logic [31:0] model_matrix [16];
  vtx_res_t    pending_results [$];
  int          error_count;
  int          result_count;
  longint      cycle_count;
  bit          quiet_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate an exact value to the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Exact dot product, rounded half up to FB fraction bits, saturated.
  function automatic longint rounded_dot(longint c[4], longint v[4], int n);
    logic signed [95:0] acc;
    acc = 0;
    for (int i = 0; i < n; i++) acc += 96'(c[i]) * 96'(v[i]);
    acc = (acc + (96'sd1 <<< (FB - 1))) >>> FB;
    if (acc > 96'(S32_MAX)) return S32_MAX;
    if (acc < 96'(S32_MIN)) return S32_MIN;
    return longint'(acc);
  endfunction

  // Apply one transaction to the matrix copy; return 1 with the vertex if a
  // result is due.
  function automatic bit transform_vertex(vtx_cmd_t c, output vtx_res_t r);
    longint vec[4], res[4], coef[4];
    longint one, wv;
    int n;
    one = longint'(1) << FB;
    r = '{default: '0};
    if (c.command == CMD_LOAD) begin
      model_matrix[c.index] = c.value;
      return 1'b0;
    end
    vec[0] = longint'(signed'(c.x));
    vec[1] = longint'(signed'(c.y));
    vec[2] = longint'(signed'(c.z));
    vec[3] = (c.mode == MODE_PROJ) ? one : longint'(signed'(c.w));
    n = (c.mode == MODE_DIR) ? 3 : 4;
    for (int i = 0; i < 4; i++) begin
      res[i] = 0;
      if (i < n) begin
        for (int j = 0; j < 4; j++)
          coef[j] = (j < n) ? longint'(signed'(model_matrix[c.transpose ? j*4+i : i*4+j]))
                            : 0;
        res[i] = rounded_dot(coef, vec, n);
      end
    end
    if (c.mode == MODE_PROJ) begin
      wv = res[3];
      if (wv == 0) begin
        r.dbz = 1'b1;
        for (int i = 0; i < 4; i++) res[i] = 0;
      end else begin
        for (int i = 0; i < 3; i++) res[i] = clamp32((res[i] * one) / wv);
        res[3] = one;
      end
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    r.w = res[3][31:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Output side: random stall bursts, and compare every result transaction.
  initial begin
    int burst;
    vtx_res_t e;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("MISMATCH unexpected result at cycle %0d", cycle_count);
          error_count++;
        end else begin
          e = pending_results.pop_front();
          if (out_x !== e.x) report_mismatch("x", out_x, e.x);
          if (out_y !== e.y) report_mismatch("y", out_y, e.y);
          if (out_z !== e.z) report_mismatch("z", out_z, e.z);
          if (out_w !== e.w) report_mismatch("w", out_w, e.w);
          if (out_divide_by_zero !== e.dbz)
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(e.dbz));
        end
      end
      if (burst > 0) begin
        burst--;
        out_stall <= (burst > 0);
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one transaction; idle bursts before it, and wait for acceptance.
  task automatic send_cmd(vtx_cmd_t c);
    vtx_res_t r;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= c.command;
    in_entry_index   <= c.index;
    in_entry_value   <= c.value;
    in_x             <= c.x;
    in_y             <= c.y;
    in_z             <= c.z;
    in_w             <= c.w;
    in_mode          <= c.mode;
    in_use_transpose <= c.transpose;
    do @(posedge clk); while (in_stall);
    if (transform_vertex(c, r)) pending_results.push_back(r);
  endtask

  function automatic vtx_cmd_t load_cmd(int idx, logic [31:0] v);
    vtx_cmd_t c;
    c = '{default: '0};
    c.command = CMD_LOAD;
    c.index = 4'(idx);
    c.value = v;
    return c;
  endfunction

  function automatic vtx_cmd_t xform_cmd(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [31:0] w, logic [1:0] m, logic t);
    vtx_cmd_t c;
    c = '{command: CMD_XFORM, index: 4'($urandom()), value: $urandom(), x: x, y: y, z: z,
          w: w, mode: m, transpose: t};
    return c;
  endfunction

  // Small fixed-point value with random fraction bits, to keep sums in range.
  function automatic logic [31:0] small_fix();
    return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF);
  endfunction

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 3))
      0: return small_fix();
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
    endcase
  endfunction

  // Directed table; expected vertex is typed in where it is obvious.
  typedef struct {
    vtx_cmd_t cmd;
    bit       has_want;
    vtx_res_t want;
  } vtx_row_t;

  localparam logic [31:0] ONE = 32'h1 << FB;
  vtx_row_t dir_rows [$];

  initial begin
    vtx_cmd_t c;
    vtx_res_t r;
    int mode_roll;
    longint timeout;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_entry_index = '0;
    in_entry_value = '0;
    in_x = '0; in_y = '0; in_z = '0; in_w = '0;
    in_mode = MODE_HOMOG;
    in_use_transpose = 1'b0;
    quiet_phase = 1'b0;
    error_count = 0;
    result_count = 0;
    for (int i = 0; i < 16; i++) model_matrix[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero matrix after reset: zero outputs, and zero w flags in projected mode.
    dir_rows.push_back('{xform_cmd(32'h7FFFFFFF, 32'h80000000, ONE, ONE, MODE_HOMOG, 0),
                         1, '{0, 0, 0, 0, 0}});
    dir_rows.push_back('{xform_cmd(ONE, ONE, ONE, ONE, MODE_PROJ, 1), 1, '{0, 0, 0, 0, 1}});
    dir_rows.push_back('{xform_cmd(ONE, 2, 3, 4, MODE_DIR, 0), 1, '{0, 0, 0, 0, 0}});
    // Identity matrix, then saturating and transposed entries.
    for (int i = 0; i < 4; i++) dir_rows.push_back('{load_cmd(i*5, ONE), 0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(32'h7FFFFFFF, 32'h80000000, 5, 32'hFFFFFFFF, MODE_HOMOG, 0),
                         1, '{32'h7FFFFFFF, 32'h80000000, 5, 32'hFFFFFFFF, 0}});
    dir_rows.push_back('{xform_cmd(ONE, ONE, ONE, 9, MODE_DIR, 1), 1, '{ONE, ONE, ONE, 0, 0}});
    dir_rows.push_back('{xform_cmd(ONE, 3*ONE, ONE, 9, MODE_RSVD, 0), 1,
                         '{ONE, 3*ONE, ONE, 9, 0}});
    dir_rows.push_back('{load_cmd(15, 2*ONE), 0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(ONE, 32'hFFFF0000, 7, 0, MODE_PROJ, 0), 0, '{default: 0}});
    dir_rows.push_back('{load_cmd(1, 32'h7FFFFFFF), 0, '{default: 0}});
    dir_rows.push_back('{load_cmd(4, 32'h80000000), 0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(32'h7FFFFFFF, 32'h7FFFFFFF, 0, ONE, MODE_HOMOG, 0),
                         0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(32'h80000000, 32'h80000000, 1, ONE, MODE_HOMOG, 1),
                         0, '{default: 0}});
    dir_rows.push_back('{load_cmd(15, 1), 0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(ONE, ONE, ONE, ONE, MODE_PROJ, 0), 0, '{default: 0}});
    dir_rows.push_back('{load_cmd(12, 32'hFFFFFFFF), 0, '{default: 0}});
    dir_rows.push_back('{xform_cmd(ONE, 0, 0, 0, MODE_PROJ, 0), 0, '{default: 0}});
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd);
      if (dir_rows[i].has_want) pending_results[$] = dir_rows[i].want;
    end

    // Random part: mostly transforms against a slowly changing matrix.
    for (int n = 0; n < 1630; n++) begin
      if (n == 1400) quiet_phase = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        c = load_cmd($urandom_range(0, 15), any_value());
      end else begin
        mode_roll = $urandom_range(0, 9);
        c = xform_cmd(any_value(), any_value(), any_value(), any_value(),
                      (mode_roll < 4) ? MODE_PROJ :
                      (mode_roll == 9) ? MODE_RSVD : 2'(mode_roll % 3),
                      $urandom_range(0, 1));
      end
      send_cmd(c);
    end
    in_valid <= 1'b0;

    timeout = cycle_count + 20000;
    while (pending_results.size() != 0 && cycle_count < timeout) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered loads and transforms in all modes, transposed and not; %0d vertices checked.",
             result_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Cycle counter with a hard limit on the run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout at cycle %0d", cycle_count);
        $display("Some tests failed");
        $finish;
      end
    end
  end
endmodule
